FILE: hdl/terminal_word_wrap_unit_defines.svh
// Assertion macros used by the checker file of the word wrap unit.
`ifndef TERMINAL_WORD_WRAP_UNIT_DEFINES_SVH
`define TERMINAL_WORD_WRAP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWWU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWWU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/twwu_pkg.sv
`default_nettype none
package twwu_pkg;

   localparam int CHAR_W           = 8;
   localparam int REP_W            = 7;
   localparam int MARGIN_W         = 6;
   localparam int COL_W            = 7;
   localparam int WORD_MAX_DEFAULT = 64;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [MARGIN_W-1:0] MARGIN_MAX = 6'd60;
   localparam logic [MARGIN_W-1:0] MARGIN_MIN = 6'd2;

   localparam logic [CHAR_W-1:0] K_NUL  = 8'd0;
   localparam logic [CHAR_W-1:0] K_QUIT = 8'd1;
   localparam logic [CHAR_W-1:0] K_BS   = 8'd8;
   localparam logic [CHAR_W-1:0] K_LF   = 8'd10;
   localparam logic [CHAR_W-1:0] K_CR   = 8'd13;
   localparam logic [CHAR_W-1:0] K_SP   = 8'd32;

   typedef enum logic [1:0] {
      JOB_QUIT,
      JOB_ECHO,
      JOB_ECHO_LF
   } job_kind_type;

   // One classified key as handed from the front to the back.
   typedef struct packed {
      job_kind_type      kind;
      logic [CHAR_W-1:0] echo_char;
      logic              store;
      logic [COL_W-1:0]  store_idx;
      logic              wrap;
      logic [COL_W-1:0]  erase_len;
      logic [COL_W-1:0]  wlen;
   } job_type;

endpackage
`default_nettype wire

FILE: hdl/twwu_channels.sv
`default_nettype none
interface twwu_req_if import twwu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface twwu_rsp_if import twwu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic [REP_W-1:0]  repeat_count;
   logic              is_quit;
   logic              last;

   modport source (output valid, output out_char, output repeat_count, output is_quit,
                   output last, input ready);
   modport sink (input valid, input out_char, input repeat_count, input is_quit,
                 input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/twwu_front.sv
`default_nettype none
module twwu_front import twwu_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [MARGIN_W-1:0] csr_wr_data,
   twwu_req_if.sink                 req_ch,
   input  wire logic                q_full,
   output      logic                push,
   output      job_type             push_job
);

   localparam int WL_W = $clog2(WORD_MAX + 1);

   logic [MARGIN_W-1:0] margin_ff;
   logic [COL_W-1:0]    cursor_ff, cursor_in;
   logic [COL_W-1:0]    brk_ff, brk_in;
   logic [WL_W-1:0]     wlen_ff, wlen_in;
   logic                accept;
   logic [CHAR_W-1:0]   ch;
   job_type             job;

   function automatic logic [MARGIN_W-1:0] clamp_margin(input logic [MARGIN_W-1:0] v);
      logic [MARGIN_W-1:0] r;
      r = v;
      if (v > MARGIN_MAX) r = MARGIN_MAX;
      if (v < MARGIN_MIN) r = MARGIN_MIN;
      return r;
   endfunction

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign ch           = req_ch.char_code;
   assign push         = accept;
   assign push_job     = job;

   always_comb begin
      cursor_in     = cursor_ff;
      brk_in        = brk_ff;
      wlen_in       = wlen_ff;
      job           = '0;
      job.kind      = JOB_ECHO;
      job.echo_char = ch;
      unique case (ch)
         K_QUIT: begin
            job.kind = JOB_QUIT;
         end
         K_SP: begin
            brk_in    = cursor_ff;
            cursor_in = cursor_ff + COL_W'(1);
            wlen_in   = '0;
         end
         K_BS: begin
            if (cursor_ff > COL_W'(1)) cursor_in = cursor_ff - COL_W'(1);
            if (wlen_ff != '0) wlen_in = wlen_ff - WL_W'(1);
         end
         K_CR: begin
            job.kind  = JOB_ECHO_LF;
            wlen_in   = '0;
            cursor_in = COL_W'(1);
            brk_in    = '0;
         end
         default: begin
            if (wlen_ff < WL_W'(WORD_MAX)) begin
               job.store     = 1'b1;
               job.store_idx = COL_W'(wlen_ff);
               wlen_in       = wlen_ff + WL_W'(1);
            end
            cursor_in = cursor_ff + COL_W'(1);
         end
      endcase
      if (ch != K_QUIT && cursor_in >= {1'b0, margin_ff}) begin
         job.wrap      = 1'b1;
         job.erase_len = (cursor_in > brk_in) ? cursor_in - brk_in : '0;
         job.wlen      = COL_W'(wlen_in);
         cursor_in     = COL_W'(wlen_in) + COL_W'(1);
         wlen_in       = '0;
         brk_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_MAX;
         cursor_ff <= COL_W'(1);
         brk_ff    <= '0;
         wlen_ff   <= '0;
      end else begin
         if (csr_wr_en) margin_ff <= clamp_margin(csr_wr_data);
         if (accept) begin
            cursor_ff <= cursor_in;
            brk_ff    <= brk_in;
            wlen_ff   <= wlen_in;
         end
      end
   end

endmodule
`default_nettype wire

FILE: hdl/twwu_queue.sv
`default_nettype none
module twwu_queue import twwu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output      logic    full,
   input  wire logic    pop,
   output      logic    avail,
   output      job_type pop_job
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full    = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign avail   = (count_ff != '0);
   assign pop_job = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (push && !pop) count_ff <= count_ff + (PTR_W + 1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

FILE: hdl/twwu_back.sv
`default_nettype none
module twwu_back import twwu_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_avail,
   input  wire job_type q_job,
   output      logic    q_pop,
   twwu_rsp_if.source   rsp_ch
);

   localparam int IDX_W = $clog2(WORD_MAX);

   typedef enum logic [8:0] {
      B_IDLE    = 9'b000000001,
      B_QUIT    = 9'b000000010,
      B_ECHO    = 9'b000000100,
      B_ECHO_LF = 9'b000001000,
      B_BS      = 9'b000010000,
      B_SP      = 9'b000100000,
      B_CR      = 9'b001000000,
      B_LF      = 9'b010000000,
      B_WORD    = 9'b100000000
   } back_state_type;

   back_state_type    state_ff, state_in, wrap_start;
   job_type           job_ff, job_in;
   logic [IDX_W-1:0]  widx_ff, widx_in;
   logic [CHAR_W-1:0] word_mem [WORD_MAX];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic [REP_W-1:0]  rep_ff;
   logic              quit_ff, last_ff;
   logic              ld, emit, e_quit, e_last, word_end;
   logic [CHAR_W-1:0] e_char;
   logic [REP_W-1:0]  e_rep;

   assign ld                  = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_char     = out_char_ff;
   assign rsp_ch.repeat_count = rep_ff;
   assign rsp_ch.is_quit      = quit_ff;
   assign rsp_ch.last         = last_ff;

   assign word_end = (COL_W'(widx_ff) == job_ff.wlen - COL_W'(1));

   always_comb begin
      if (!job_ff.wrap) wrap_start = B_IDLE;
      else if (job_ff.erase_len != '0) wrap_start = B_BS;
      else wrap_start = B_CR;
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      widx_in  = widx_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      e_char   = K_NUL;
      e_rep    = REP_W'(1);
      e_quit   = 1'b0;
      e_last   = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_avail) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               state_in = (q_job.kind == JOB_QUIT) ? B_QUIT : B_ECHO;
            end
         end
         B_QUIT: begin
            if (ld) begin
               emit     = 1'b1;
               e_quit   = 1'b1;
               e_last   = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_ECHO: begin
            if (ld) begin
               emit     = 1'b1;
               e_char   = job_ff.echo_char;
               e_last   = (job_ff.kind != JOB_ECHO_LF) && !job_ff.wrap;
               state_in = (job_ff.kind == JOB_ECHO_LF) ? B_ECHO_LF : wrap_start;
            end
         end
         B_ECHO_LF: begin
            if (ld) begin
               emit     = 1'b1;
               e_char   = K_LF;
               e_last   = !job_ff.wrap;
               state_in = wrap_start;
            end
         end
         B_BS: begin
            if (ld) begin
               emit     = 1'b1;
               e_char   = K_BS;
               e_rep    = job_ff.erase_len;
               state_in = B_SP;
            end
         end
         B_SP: begin
            if (ld) begin
               emit     = 1'b1;
               e_char   = K_SP;
               e_rep    = job_ff.erase_len;
               state_in = B_CR;
            end
         end
         B_CR: begin
            if (ld) begin
               emit     = 1'b1;
               e_char   = K_CR;
               state_in = B_LF;
            end
         end
         B_LF: begin
            if (ld) begin
               emit     = 1'b1;
               e_char   = K_LF;
               e_last   = (job_ff.wlen == '0);
               state_in = (job_ff.wlen == '0) ? B_IDLE : B_WORD;
            end
         end
         B_WORD: begin
            if (ld) begin
               emit   = 1'b1;
               e_char = rd_data_ff;
               e_last = word_end;
               if (word_end) begin
                  state_in = B_IDLE;
                  widx_in  = '0;
               end else begin
                  widx_in = widx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         if (ld) rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (ld && emit) begin
         out_char_ff <= e_char;
         rep_ff      <= e_rep;
         quit_ff     <= e_quit;
         last_ff     <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_job.store) word_mem[q_job.store_idx[IDX_W-1:0]] <= q_job.echo_char;
      rd_data_ff <= word_mem[widx_in];
   end

endmodule
`default_nettype wire

FILE: hdl/terminal_word_wrap_unit.sv
`default_nettype none
// Greedy word wrap for a character terminal: each key code taken on req_ch is echoed on
// rsp_ch as one or more runs of characters, and a key that brings the cursor to the right
// margin (csr_wr_data, clamped to 2..60, reset 60) erases the partial word, starts a new
// line and reprints it. The front classifies a key and updates the cursor in the cycle it
// is taken, so keys enter at one per cycle until the four-entry queue is full. The back
// fetches a key from the queue and then issues its results in order while the sink is
// ready, and takes no new key before it has issued the last result of the one before.
// A wrap reprints the word buffer one character per cycle while the sink is ready. The
// word buffer is not cleared at reset and needs no setup time.
module terminal_word_wrap_unit import twwu_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEFAULT
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                csr_wr_en,
   input wire logic [MARGIN_W-1:0] csr_wr_data,
   twwu_req_if.sink                req_ch,
   twwu_rsp_if.source              rsp_ch
);

   logic    push, full, pop, avail;
   job_type push_job, pop_job;

   twwu_front #(.WORD_MAX(WORD_MAX)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .q_full      (full),
      .push        (push),
      .push_job    (push_job)
   );

   twwu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .avail    (avail),
      .pop_job  (pop_job)
   );

   twwu_back #(.WORD_MAX(WORD_MAX)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_avail (avail),
      .q_job   (pop_job),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire

FILE: hdl/twwu_checker.sv
`default_nettype none
`include "terminal_word_wrap_unit_defines.svh"
module twwu_checker import twwu_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CHAR_W-1:0] out_char,
   input wire logic [REP_W-1:0]  repeat_count,
   input wire logic              is_quit,
   input wire logic              last
);

   // A quit item always answers with a single result of its own form.
   `TWWU_ASSERT_SAME(a_quit_form, rsp_valid && is_quit,
      out_char == K_NUL && repeat_count == REP_W'(1) && last, "malformed quit item")

   `TWWU_ASSERT_SAME(a_rep_range, rsp_valid,
      repeat_count != '0 && repeat_count <= REP_W'(64), "repeat count out of range")

   // Only the erase runs of a wrap repeat a character.
   `TWWU_ASSERT_SAME(a_rep_single, rsp_valid && repeat_count != REP_W'(1),
      !is_quit && (out_char == K_BS || out_char == K_SP), "unexpected repeated character")

   `TWWU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(out_char) && $stable(repeat_count) && $stable(last),
      "stalled item changed")

endmodule

bind terminal_word_wrap_unit twwu_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .out_char     (rsp_ch.out_char),
   .repeat_count (rsp_ch.repeat_count),
   .is_quit      (rsp_ch.is_quit),
   .last         (rsp_ch.last)
);
`default_nettype wire
